// ----- design/key_press_duration_classifier_defines.svh -----
// ----------------------------------------------------------------------------
// key press duration classifier assertion macros
// shared concurrent assertion forms for the classifier rtl
// ----------------------------------------------------------------------------
`ifndef KEY_PRESS_DURATION_CLASSIFIER_DEFINES_SVH
`define KEY_PRESS_DURATION_CLASSIFIER_DEFINES_SVH

// checked on every clock edge outside reset
`define KPDC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define KPDC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/kpdc_pkg.sv -----
// ----------------------------------------------------------------------------
// kpdc_pkg
// types and constants of the key press duration classifier
// ----------------------------------------------------------------------------
`default_nettype none

package kpdc_pkg;

  localparam int NUM_KEYS = 32;
  localparam int KEY_AW   = $clog2(NUM_KEYS);

  localparam int KEY_W    = 5;
  localparam int TIME_W   = 32;
  localparam int THR_W    = 16;
  localparam int CFG_IDX_W = 1;

  // input item: key_index, key_closed, now_ms, padded to bytes
  localparam int IN_BITS   = KEY_W + 1 + TIME_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  // result item: state_changed, new_state, release_class, padded to bytes
  localparam int OUT_BITS   = 1 + 3 + 2;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [THR_W-1:0] SHORT_PRESS_RESET = 16'd500;
  localparam logic [THR_W-1:0] LONG_PRESS_RESET  = 16'd1000;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PRESSED  = 3'd1,
    PH_HOLD     = 3'd2,
    PH_LONG     = 3'd3,
    PH_RELEASED = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_SHORT = 2'd1,
    CLS_HOLD  = 2'd2,
    CLS_LONG  = 2'd3
  } release_class_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_PRESS = 1'd0,
    REG_LONG_PRESS  = 1'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

// ----- design/key_press_duration_classifier.sv -----
// ----------------------------------------------------------------------------
// key_press_duration_classifier
// per-key press / hold / long hold / release tracker with duration classes
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  s_*       in         s_tvalid / s_tready   key sample (key_index, key_closed, now_ms)
//  m_*       out        m_tvalid / m_tready   result (state_changed, new_state, release_class)
//  cfg_*     in         cfg_valid / cfg_ready threshold write (cfg_index, cfg_data)
//
//  one result per sample; a sample passes through the input register and
//  then sits in the result register until the result is taken
//  rate is one sample per cycle while the result stream is not stalled, set by
//  the single read-modify-write of the per-key phase and press-start registers
//  a stalled result holds in the result register while the input register
//  still takes one more sample; s_tready drops only when both are full
//  rst clears all key phases to idle, the pipeline valids and the thresholds
//  (500 ms and 1000 ms); cfg writes are taken every cycle
//
`default_nettype none
`include "key_press_duration_classifier_defines.svh"

module key_press_duration_classifier (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // sample stream
  input  wire logic                            s_tvalid,
  output      logic                            s_tready,
  // [4:0] key_index, [5] key_closed, [37:6] now_ms, [39:38] zero
  input  wire logic [kpdc_pkg::IN_DATA_W-1:0]  s_tdata,
  // result stream
  output      logic                            m_tvalid,
  input  wire logic                            m_tready,
  // [0] state_changed, [3:1] new_state, [5:4] release_class, [7:6] zero
  output      logic [kpdc_pkg::OUT_DATA_W-1:0] m_tdata,
  // configuration writes
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [kpdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kpdc_pkg::THR_W-1:0]      cfg_data
);

  import kpdc_pkg::*;

  // threshold registers
  logic [THR_W-1:0] short_ms;
  logic [THR_W-1:0] long_ms;

  // per-key state
  phase_t            key_phase   [NUM_KEYS];
  logic [TIME_W-1:0] press_start [NUM_KEYS];

  // input register
  logic              in_valid;
  logic [KEY_W-1:0]  in_key;
  logic              in_closed;
  logic [TIME_W-1:0] in_now;

  // result register
  logic           out_changed;
  phase_t         out_state;
  release_class_t out_class;

  // update logic
  logic              advance;
  logic              key_ok;
  logic [KEY_AW-1:0] key_addr;
  phase_t            cur_phase;
  logic [TIME_W-1:0] elapsed;
  logic              past_short;
  logic              past_long;
  phase_t            phase_next;
  logic              changed_next;
  release_class_t    class_next;
  logic              stamp;

  // ---------------------------------------------------------------------------
  // configuration: always ready, out-of-list indexes cannot occur at this width
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_ms <= SHORT_PRESS_RESET;
      long_ms  <= LONG_PRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SHORT_PRESS: short_ms <= cfg_data;
        REG_LONG_PRESS:  long_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: the input register moves on when the result register is free
  // or being emptied in this cycle
  // ---------------------------------------------------------------------------
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_key    <= s_tdata[KEY_W-1:0];
      in_closed <= s_tdata[KEY_W];
      in_now    <= s_tdata[KEY_W+1 +: TIME_W];
    end
  end

  // ---------------------------------------------------------------------------
  // per-key phase rules
  // ---------------------------------------------------------------------------
  assign key_ok     = 32'(in_key) < NUM_KEYS;
  assign key_addr   = in_key[KEY_AW-1:0];
  assign cur_phase  = key_phase[key_addr];
  // wrapping elapsed time since the press began
  assign elapsed    = in_now - press_start[key_addr];
  assign past_short = elapsed > TIME_W'(short_ms);
  assign past_long  = elapsed > TIME_W'(long_ms);

  always_comb begin
    phase_next   = cur_phase;
    changed_next = 1'b0;
    class_next   = CLS_NONE;
    stamp        = 1'b0;
    unique case (cur_phase)
      PH_IDLE: begin
        if (in_closed) begin
          phase_next   = PH_PRESSED;
          changed_next = 1'b1;
          stamp        = 1'b1;
        end
      end
      PH_PRESSED: begin
        if (past_short) begin
          phase_next   = PH_HOLD;
          changed_next = 1'b1;
        end else if (!in_closed) begin
          phase_next   = PH_RELEASED;
          changed_next = 1'b1;
          class_next   = CLS_SHORT;
        end
      end
      PH_HOLD: begin
        if (past_long) begin
          phase_next   = PH_LONG;
          changed_next = 1'b1;
        end else if (!in_closed) begin
          phase_next   = PH_RELEASED;
          changed_next = 1'b1;
          class_next   = CLS_HOLD;
        end
      end
      PH_LONG: begin
        if (!in_closed) begin
          phase_next   = PH_RELEASED;
          changed_next = 1'b1;
          class_next   = CLS_LONG;
        end
      end
      // released goes back to idle without an event; so do unused codes
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // state write-back happens together with the result load, so a sample for
  // the same key in the next cycle already sees the new phase
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_phase[i] <= PH_IDLE;
      end
    end else if (advance && key_ok) begin
      key_phase[key_addr] <= phase_next;
    end
  end

  // press start is only read after a press stamped it
  always_ff @(posedge clk) begin
    if (advance && key_ok && stamp) begin
      press_start[key_addr] <= in_now;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (key_ok) begin
        out_changed <= changed_next;
        out_state   <= phase_next;
        out_class   <= class_next;
      end else begin
        // unknown key: sample ignored, all result fields zero
        out_changed <= 1'b0;
        out_state   <= PH_IDLE;
        out_class   <= CLS_NONE;
      end
    end
  end

  assign m_tdata = {(OUT_DATA_W - OUT_BITS)'(0), out_class, out_state, out_changed};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `KPDC_ASSERT(a_release_has_class,
    m_tvalid && out_state == PH_RELEASED |-> out_changed && out_class != CLS_NONE,
    "release result without a press class")
  `KPDC_ASSERT(a_class_only_on_release,
    m_tvalid && out_class != CLS_NONE |-> out_state == PH_RELEASED,
    "press class reported outside a release")
  `KPDC_ASSERT(a_change_not_idle,
    m_tvalid && out_changed |-> out_state != PH_IDLE,
    "change reported into idle")
  `KPDC_ASSERT(a_ready_when_result_free,
    !m_tvalid || !in_valid |-> s_tready,
    "input stalled with a free stage")
  `KPDC_ASSERT_ALWAYS(a_no_result_after_reset,
    rst |=> !m_tvalid,
    "result valid right after reset")

endmodule

`default_nettype wire
